>>> rtl/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off while reset is active
`define ASSERT_IMPLY(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("implication check failed");

// next-cycle implication, off while reset is active
`define ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

>>> rtl/wsfr_pkg.sv
package wsfr_pkg;

    localparam int unsigned PADDR_W = 3;

    localparam logic REG_MAX_MSG  = 1'b0;
    localparam logic REG_REQ_MASK = 1'b1;

    localparam logic [31:0] MAX_MSG_RESET  = 32'd8388608;
    localparam logic        REQ_MASK_RESET = 1'b1;

    localparam logic [3:0] OP_CONT   = 4'h0;
    localparam logic [3:0] OP_TEXT   = 4'h1;
    localparam logic [3:0] OP_BINARY = 4'h2;
    localparam logic [3:0] OP_CLOSE  = 4'h8;
    localparam logic [3:0] OP_PING   = 4'h9;
    localparam logic [3:0] OP_PONG   = 4'hA;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_PROTOCOL = 2'd1;
    localparam logic [1:0] ST_TOO_BIG  = 2'd2;

    localparam logic [6:0]  LEN7_EXT16     = 7'd126;
    localparam logic [63:0] MIN_LEN16      = 64'd126;
    localparam logic [63:0] MIN_LEN64      = 64'd65536;
    localparam logic [63:0] CTRL_MAX_LEN   = 64'd125;
    localparam logic [3:0]  HC_EXT16_START = 4'd12;
    localparam logic [3:0]  HC_EXT16_END   = 4'd14;
    localparam logic [3:0]  HC_EXT64_END   = 4'd8;
    localparam logic [3:0]  HC_KEY_END     = 4'd4;

    typedef struct packed {
        logic [31:0] max_message_bytes;
        logic        require_mask;
    } t_cfg;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic [3:0] msg_opcode;
        logic       message_end;
        logic [1:0] status;
    } t_result;

    function automatic logic is_known(input logic [3:0] op);
        is_known = (op == OP_CONT) || (op == OP_TEXT) || (op == OP_BINARY) ||
                   (op == OP_CLOSE) || (op == OP_PING) || (op == OP_PONG);
    endfunction

endpackage

>>> rtl/wsfr_cfg_regs.sv
module wsfr_cfg_regs (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [wsfr_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    output wsfr_pkg::t_cfg               o_cfg
);

    logic [31:0] r_max_message_bytes;
    logic        r_require_mask;
    logic        w_wr;
    logic        w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign w_idx  = paddr[2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_message_bytes <= wsfr_pkg::MAX_MSG_RESET;
            r_require_mask      <= wsfr_pkg::REQ_MASK_RESET;
        end else if (w_wr) begin
            if (w_idx == wsfr_pkg::REG_MAX_MSG) begin
                r_max_message_bytes <= pwdata;
            end else begin
                r_require_mask <= pwdata[0];
            end
        end
    end

    always_comb begin
        if (w_idx == wsfr_pkg::REG_REQ_MASK) begin
            prdata = {31'd0, r_require_mask};
        end else begin
            prdata = r_max_message_bytes;
        end
    end

    assign o_cfg.max_message_bytes = r_max_message_bytes;
    assign o_cfg.require_mask      = r_require_mask;

endmodule

>>> rtl/wsfr_parser.sv
module wsfr_parser (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [7:0]        i_rx_byte,
    input  wsfr_pkg::t_cfg    i_cfg,
    output logic              o_res_valid,
    output wsfr_pkg::t_result o_res
);

    localparam logic [2:0] PH_HDR0    = 3'd0;
    localparam logic [2:0] PH_LEN7    = 3'd1;
    localparam logic [2:0] PH_EXTLEN  = 3'd2;
    localparam logic [2:0] PH_KEY     = 3'd3;
    localparam logic [2:0] PH_PAYLOAD = 3'd4;

    logic [2:0]  r_phase,           n_phase;
    logic [3:0]  r_header_count,    n_header_count;
    logic        r_frame_fin,       n_frame_fin;
    logic [3:0]  r_frame_opcode,    n_frame_opcode;
    logic        r_frame_masked,    n_frame_masked;
    logic [63:0] r_length_accum,    n_length_accum;
    logic [31:0] r_mask_key,        n_mask_key;
    logic [31:0] r_payload_left,    n_payload_left;
    logic [1:0]  r_mask_index,      n_mask_index;
    logic        r_assembling,      n_assembling;
    logic [3:0]  r_assembly_opcode, n_assembly_opcode;
    logic [32:0] r_message_count,   n_message_count;
    logic        r_error_stuck,     n_error_stuck;

    logic [63:0] w_acc_shift;
    logic [3:0]  w_hc_inc;
    logic [63:0] w_ld_len;
    logic        w_ld_masked;
    logic        w_ld_too_big;
    logic        w_ld_ctrl_bad;
    logic [31:0] w_key_shift;
    logic [31:0] w_hd_len;
    logic [33:0] w_asm_sum;
    logic        w_asm_too_big;
    logic [3:0]  w_msg_op;
    logic [31:0] w_pl_dec;
    logic [7:0]  w_key_byte;

    assign w_acc_shift   = {r_length_accum[55:0], i_rx_byte};
    assign w_hc_inc      = r_header_count + 4'd1;
    assign w_ld_len      = (r_phase == PH_LEN7) ? {57'd0, i_rx_byte[6:0]} : w_acc_shift;
    assign w_ld_masked   = (r_phase == PH_LEN7) ? i_rx_byte[7] : r_frame_masked;
    assign w_ld_too_big  = (w_ld_len[63:32] != 32'd0) ||
                           (w_ld_len[31:0] > i_cfg.max_message_bytes);
    assign w_ld_ctrl_bad = r_frame_opcode[3] &&
                           (!r_frame_fin || (w_ld_len > wsfr_pkg::CTRL_MAX_LEN));
    assign w_key_shift   = {r_mask_key[23:0], i_rx_byte};
    assign w_hd_len      = (r_phase == PH_KEY) ? r_length_accum[31:0] : w_ld_len[31:0];
    assign w_asm_sum     = {1'b0, r_message_count} + {2'b00, w_hd_len};
    assign w_asm_too_big = w_asm_sum > {2'b00, i_cfg.max_message_bytes};
    assign w_msg_op      = (r_frame_opcode == wsfr_pkg::OP_CONT) ? r_assembly_opcode
                                                                 : r_frame_opcode;
    assign w_pl_dec      = r_payload_left - 32'd1;

    always_comb begin
        unique case (r_mask_index)
            2'd0:    w_key_byte = r_mask_key[31:24];
            2'd1:    w_key_byte = r_mask_key[23:16];
            2'd2:    w_key_byte = r_mask_key[15:8];
            default: w_key_byte = r_mask_key[7:0];
        endcase
    end

    always_comb begin
        logic v_ld;
        logic v_hd;
        logic v_end;
        v_ld              = 1'b0;
        v_hd              = 1'b0;
        v_end             = 1'b0;
        n_phase           = r_phase;
        n_header_count    = r_header_count;
        n_frame_fin       = r_frame_fin;
        n_frame_opcode    = r_frame_opcode;
        n_frame_masked    = r_frame_masked;
        n_length_accum    = r_length_accum;
        n_mask_key        = r_mask_key;
        n_payload_left    = r_payload_left;
        n_mask_index      = r_mask_index;
        n_assembling      = r_assembling;
        n_assembly_opcode = r_assembly_opcode;
        n_message_count   = r_message_count;
        n_error_stuck     = r_error_stuck;
        o_res_valid       = 1'b0;
        o_res             = '0;

        if (i_accept && !r_error_stuck) begin
            unique case (r_phase)
                PH_LEN7: begin
                    n_frame_masked = i_rx_byte[7];
                    if (i_rx_byte[6:0] < wsfr_pkg::LEN7_EXT16) begin
                        n_length_accum = {57'd0, i_rx_byte[6:0]};
                        v_ld           = 1'b1;
                    end else begin
                        n_length_accum = '0;
                        n_header_count = (i_rx_byte[6:0] == wsfr_pkg::LEN7_EXT16)
                                         ? wsfr_pkg::HC_EXT16_START : 4'd0;
                        n_phase        = PH_EXTLEN;
                    end
                end
                PH_EXTLEN: begin
                    n_length_accum = w_acc_shift;
                    n_header_count = w_hc_inc;
                    if (w_hc_inc == wsfr_pkg::HC_EXT16_END) begin
                        if (w_acc_shift < wsfr_pkg::MIN_LEN16) begin
                            n_error_stuck = 1'b1;
                            o_res_valid   = 1'b1;
                            o_res.status  = wsfr_pkg::ST_PROTOCOL;
                        end else begin
                            v_ld = 1'b1;
                        end
                    end else if (w_hc_inc == wsfr_pkg::HC_EXT64_END) begin
                        if (w_acc_shift[63] || (w_acc_shift < wsfr_pkg::MIN_LEN64)) begin
                            n_error_stuck = 1'b1;
                            o_res_valid   = 1'b1;
                            o_res.status  = wsfr_pkg::ST_PROTOCOL;
                        end else begin
                            v_ld = 1'b1;
                        end
                    end
                end
                PH_KEY: begin
                    n_mask_key     = w_key_shift;
                    n_header_count = w_hc_inc;
                    if (w_hc_inc >= wsfr_pkg::HC_KEY_END) begin
                        v_hd = 1'b1;
                    end
                end
                PH_PAYLOAD: begin
                    n_mask_index   = r_mask_index + 2'd1;
                    n_payload_left = w_pl_dec;
                    v_end          = (w_pl_dec == 32'd0) && r_frame_fin;
                    if (w_pl_dec == 32'd0) begin
                        n_phase = PH_HDR0;
                    end
                    if (v_end && (r_frame_opcode == wsfr_pkg::OP_CONT)) begin
                        n_assembling = 1'b0;
                    end
                    o_res_valid       = 1'b1;
                    o_res.out_byte    = i_rx_byte ^ w_key_byte;
                    o_res.byte_valid  = 1'b1;
                    o_res.msg_opcode  = w_msg_op;
                    o_res.message_end = v_end;
                    o_res.status      = wsfr_pkg::ST_OK;
                end
                default: begin
                    n_frame_fin    = i_rx_byte[7];
                    n_frame_opcode = i_rx_byte[3:0];
                    if ((i_rx_byte[6:4] != 3'd0) || !wsfr_pkg::is_known(i_rx_byte[3:0])) begin
                        n_error_stuck = 1'b1;
                        o_res_valid   = 1'b1;
                        o_res.status  = wsfr_pkg::ST_PROTOCOL;
                    end else begin
                        n_phase = PH_LEN7;
                    end
                end
            endcase

            // length complete
            if (v_ld) begin
                priority if (w_ld_ctrl_bad) begin
                    n_error_stuck = 1'b1;
                    o_res_valid   = 1'b1;
                    o_res.status  = wsfr_pkg::ST_PROTOCOL;
                end else if (w_ld_too_big) begin
                    n_error_stuck = 1'b1;
                    o_res_valid   = 1'b1;
                    o_res.status  = wsfr_pkg::ST_TOO_BIG;
                end else if (w_ld_masked) begin
                    n_mask_key     = '0;
                    n_phase        = PH_KEY;
                    n_header_count = 4'd0;
                end else if (i_cfg.require_mask) begin
                    n_error_stuck = 1'b1;
                    o_res_valid   = 1'b1;
                    o_res.status  = wsfr_pkg::ST_PROTOCOL;
                end else begin
                    n_mask_key = '0;
                    v_hd       = 1'b1;
                end
            end

            // header complete: fragment order and message size
            if (v_hd) begin
                priority if (!r_frame_opcode[3] && (r_frame_opcode == wsfr_pkg::OP_CONT) &&
                             !r_assembling) begin
                    n_error_stuck = 1'b1;
                    o_res_valid   = 1'b1;
                    o_res.status  = wsfr_pkg::ST_PROTOCOL;
                end else if (!r_frame_opcode[3] && (r_frame_opcode == wsfr_pkg::OP_CONT) &&
                             w_asm_too_big) begin
                    n_error_stuck = 1'b1;
                    o_res_valid   = 1'b1;
                    o_res.status  = wsfr_pkg::ST_TOO_BIG;
                end else if (!r_frame_opcode[3] && (r_frame_opcode != wsfr_pkg::OP_CONT) &&
                             r_assembling) begin
                    n_error_stuck = 1'b1;
                    o_res_valid   = 1'b1;
                    o_res.status  = wsfr_pkg::ST_PROTOCOL;
                end else begin
                    if (!r_frame_opcode[3]) begin
                        if (r_frame_opcode == wsfr_pkg::OP_CONT) begin
                            n_message_count = w_asm_sum[32:0];
                        end else if (!r_frame_fin) begin
                            n_assembling      = 1'b1;
                            n_assembly_opcode = r_frame_opcode;
                            n_message_count   = {1'b0, w_hd_len};
                        end
                    end
                    n_payload_left = w_hd_len;
                    n_mask_index   = 2'd0;
                    if (w_hd_len != 32'd0) begin
                        n_phase = PH_PAYLOAD;
                    end else begin
                        n_phase = PH_HDR0;
                        if (r_frame_fin) begin
                            if (r_frame_opcode == wsfr_pkg::OP_CONT) begin
                                n_assembling = 1'b0;
                            end
                            o_res_valid       = 1'b1;
                            o_res.msg_opcode  = w_msg_op;
                            o_res.message_end = 1'b1;
                            o_res.status      = wsfr_pkg::ST_OK;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase           <= PH_HDR0;
            r_header_count    <= '0;
            r_frame_fin       <= 1'b0;
            r_frame_opcode    <= '0;
            r_frame_masked    <= 1'b0;
            r_length_accum    <= '0;
            r_mask_key        <= '0;
            r_payload_left    <= '0;
            r_mask_index      <= '0;
            r_assembling      <= 1'b0;
            r_assembly_opcode <= '0;
            r_message_count   <= '0;
            r_error_stuck     <= 1'b0;
        end else begin
            r_phase           <= n_phase;
            r_header_count    <= n_header_count;
            r_frame_fin       <= n_frame_fin;
            r_frame_opcode    <= n_frame_opcode;
            r_frame_masked    <= n_frame_masked;
            r_length_accum    <= n_length_accum;
            r_mask_key        <= n_mask_key;
            r_payload_left    <= n_payload_left;
            r_mask_index      <= n_mask_index;
            r_assembling      <= n_assembling;
            r_assembly_opcode <= n_assembly_opcode;
            r_message_count   <= n_message_count;
            r_error_stuck     <= n_error_stuck;
        end
    end

endmodule

>>> rtl/wsfr_out_stage.sv
module wsfr_out_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  wsfr_pkg::t_result i_res,
    input  logic              i_out_ready,
    output logic              o_in_ready,
    output logic              o_out_valid,
    output wsfr_pkg::t_result o_res
);

    logic              r_valid;
    wsfr_pkg::t_result r_res;

    assign o_in_ready  = !r_valid || i_out_ready;
    assign o_out_valid = r_valid;
    assign o_res       = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_load) begin
            r_res <= i_res;
        end
    end

endmodule

>>> rtl/websocket_frame_receiver_core.sv
// Frame receiver for the WebSocket wire format: takes the received stream one byte per
// transaction and gives at most one result per byte, at a sustained rate of one byte per
// cycle; a result appears in the cycle after its byte is taken, set by the single output
// register behind the parse logic, and while that register holds a result that the sink is
// not ready for, no byte is taken. Header bytes give no result, payload bytes come out
// unmasked with the message opcode and an end mark, and a frame that ends a message with no
// payload gives one empty end result. The first protocol or size error gives one status
// result, after which no further result appears until reset. Size limit and mask requirement
// must be set via the register port while the block is idle; the block does not enforce it.
module websocket_frame_receiver_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_rx_valid,
    output logic                         o_rx_ready,
    input  logic [7:0]                   i_rx_byte,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [7:0]                   o_out_byte,
    output logic                         o_byte_valid,
    output logic [3:0]                   o_msg_opcode,
    output logic                         o_message_end,
    output logic [1:0]                   o_status,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [wsfr_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);

    wsfr_pkg::t_cfg    w_cfg;
    wsfr_pkg::t_result w_res;
    wsfr_pkg::t_result w_out;
    logic              w_res_valid;
    logic              w_accept;

    assign w_accept = i_rx_valid && o_rx_ready;

    wsfr_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    wsfr_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_accept),
        .i_rx_byte   (i_rx_byte),
        .i_cfg       (w_cfg),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    wsfr_out_stage u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (w_res_valid),
        .i_res       (w_res),
        .i_out_ready (i_out_ready),
        .o_in_ready  (o_rx_ready),
        .o_out_valid (o_out_valid),
        .o_res       (w_out)
    );

    assign o_out_byte    = w_out.out_byte;
    assign o_byte_valid  = w_out.byte_valid;
    assign o_msg_opcode  = w_out.msg_opcode;
    assign o_message_end = w_out.message_end;
    assign o_status      = w_out.status;

endmodule

>>> rtl/wsfr_checker.sv
`include "assert_macros.svh"

module wsfr_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         o_out_valid,
    input logic                         i_out_ready,
    input logic [7:0]                   o_out_byte,
    input logic                         o_byte_valid,
    input logic [3:0]                   o_msg_opcode,
    input logic                         o_message_end,
    input logic [1:0]                   o_status,
    input logic                         psel,
    input logic                         pready
);

    logic r_err_taken;
    logic w_err_xact;

    // error result taken by the sink
    assign w_err_xact = o_out_valid && i_out_ready && (o_status != wsfr_pkg::ST_OK);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_err_taken <= 1'b0;
        end else if (w_err_xact) begin
            r_err_taken <= 1'b1;
        end
    end

    `ASSERT_IMPLY(a_no_out_after_error, i_clk, i_rst_n, r_err_taken, !o_out_valid)

    `ASSERT_IMPLY(a_error_result_empty, i_clk, i_rst_n,
        o_out_valid && (o_status != wsfr_pkg::ST_OK),
        !o_byte_valid && !o_message_end && (o_msg_opcode == wsfr_pkg::OP_CONT))

    `ASSERT_IMPLY(a_empty_result_zero_byte, i_clk, i_rst_n,
        o_out_valid && !o_byte_valid, o_out_byte == 8'd0)

    `ASSERT_NEXT(a_stalled_result_holds, i_clk, i_rst_n,
        o_out_valid && !i_out_ready,
        o_out_valid && $stable(o_out_byte) && $stable(o_status) && $stable(o_message_end))

    `ASSERT_IMPLY(a_pready_high, i_clk, i_rst_n, psel, pready)

endmodule

bind websocket_frame_receiver_core wsfr_checker u_wsfr_checker (.*);
